// ----- design/itra_pkg.sv -----
// Package for the radix ASCII converter: widths, character codes and helpers.
`timescale 1ns / 1ps
`default_nettype none

package itra_pkg;

  // Default and fixed widths
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned VALUE_IN_W      = 32;
  localparam int unsigned RADIX_W         = 6;
  localparam int unsigned CHAR_W          = 7;

  // Radix limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [RADIX_W-1:0] DIGIT_MAX_NUMERIC = 6'd9;
  localparam logic [RADIX_W-1:0] LETTER_BASE       = 6'd10;

  // Clamp a raw radix into 2..36
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // Digit value to ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_MAX_NUMERIC) begin
      c = {1'b0, d - LETTER_BASE} + CH_LOWER_A;
    end else begin
      c = {1'b0, d} + CH_ZERO;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/integer_to_radix_ascii_top.sv -----
// Integer to ASCII converter in radix 2..36, most significant digit first.
// Conversion: the shared bit-serial divider produces each digit (one quotient
// bit per cycle), then each digit is read from the digit stack (ST_RD presents
// the address, ST_EM emits the char); '-' appears the cycle after start.
// Throughput: one word per conversion; busy stays high until the last char.
// The receiver cannot stall. Reset (async, active low) returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_ascii_top #(
  parameter int unsigned VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [itra_pkg::VALUE_IN_W-1:0] value_i,
  input  wire logic [itra_pkg::RADIX_W-1:0]  radix_i,
  input  wire logic                          negative_i,
  output logic                               valid_o,
  output logic      [itra_pkg::CHAR_W-1:0]   char_out_o,
  output logic                               last_o
);

  import itra_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned AW = $clog2(W);
  localparam int unsigned NW = $clog2(W + 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_EM   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [NW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [RADIX_W-1:0]  radix_q;
  logic                valid_q, valid_d;
  logic                last_q, last_d;
  logic [CHAR_W-1:0]   char_q, char_d;

  logic                accept;
  logic [W-1:0]        val_w;
  logic [W-1:0]        val_sel;
  logic [RADIX_W-1:0]  radix_c;

  logic                div_start;
  logic [W-1:0]        div_dividend;
  logic [RADIX_W-1:0]  div_divisor;
  logic                div_done;
  logic [W-1:0]        div_quot;
  logic [RADIX_W-1:0]  div_rem;

  logic                ram_we;
  logic [RADIX_W-1:0]  ram_rdata;

  // Fit the input word to the working width
  if (W > VALUE_IN_W) begin : g_ext
    assign val_w = {{(W - VALUE_IN_W){1'b0}}, value_i};
  end else begin : g_trunc
    assign val_w = value_i[W-1:0];
  end

  assign accept  = start && (state_q == ST_IDLE);
  assign val_sel = negative_i ? (~val_w + 1'b1) : val_w;
  assign radix_c = clamp_radix(radix_i);

  // Divider hookup: first digit from the input, later ones from the quotient
  assign div_dividend = accept ? val_sel : div_quot;
  assign div_divisor  = accept ? radix_c : radix_q;
  assign div_start    = accept || ((state_q == ST_DIV) && div_done && (div_quot != '0));
  assign ram_we       = (state_q == ST_DIV) && div_done;

  itra_div #(
    .W (W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Digit stack, least significant digit at address 0
  itra_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (W)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (div_rem),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    valid_d = 1'b0;
    last_d  = last_q;
    char_d  = char_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          state_d = ST_DIV;
          if (negative_i) begin
            valid_d = 1'b1;
            char_d  = CH_MINUS;
            last_d  = 1'b0;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          cnt_d = cnt_q + 1'b1;
          if (div_quot == '0) begin
            ptr_d   = cnt_q[AW-1:0];
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        // read address is presented this cycle
        state_d = ST_EM;
      end
      ST_EM: begin
        valid_d = 1'b1;
        char_d  = digit_char(ram_rdata);
        last_d  = (ptr_q == '0);
        if (ptr_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d   = ptr_q - 1'b1;
          state_d = ST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
    end
  end

  // Output word and held radix
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    if (accept) begin
      radix_q <= radix_c;
    end
  end

  assign busy       = (state_q != ST_IDLE);
  assign valid_o    = valid_q;
  assign char_out_o = char_q;
  assign last_o     = last_q;

  // Checks
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy)
    else $error("last char shown while still busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy)
    else $error("non-final char shown while idle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

endmodule

`default_nettype wire

// ----- design/itra_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module itra_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/itra_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
`timescale 1ns / 1ps
`default_nettype none

module itra_div #(
  parameter int unsigned W = itra_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [W-1:0]                  dividend_i,
  input  wire logic [itra_pkg::RADIX_W-1:0]  divisor_i,
  output logic                               done_o,
  output logic      [W-1:0]                  quot_o,
  output logic      [itra_pkg::RADIX_W-1:0]  rem_o
);

  import itra_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]         quot_q, quot_d;
  logic [RADIX_W-1:0]   rem_q, rem_d;
  logic [RADIX_W-1:0]   dvs_q;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [RADIX_W:0]     rem_sh;
  logic [RADIX_W:0]     rem_diff;
  logic                 fits;

  // One restoring step: shift in next dividend bit, trial subtract
  assign rem_sh   = {rem_q, quot_q[W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};
  assign fits     = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(W);
    end else if (cnt_q != '0) begin
      quot_d = {quot_q[W-2:0], fits};
      rem_d  = fits ? rem_diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
